/* sv/checked_frame_receiver_assert.svh */
// ---------------------------------------------------------------------------
// checked_frame_receiver_assert.svh
// assertion macros for the frame receiver
// ---------------------------------------------------------------------------
`ifndef CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKED_FRAME_RECEIVER_ASSERT_SVH

// clocked assertion, off during reset
`define CRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion, checked during reset too
`define CRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/crf_pkg.sv */
// ---------------------------------------------------------------------------
// crf_pkg
// types and constants of the checked frame receiver
// ---------------------------------------------------------------------------
package crf_pkg;

  localparam int MAX_FRAME_DEF = 24;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BADHDR  = 2'd2;
  localparam logic [1:0] ST_BADSUM  = 2'd3;

  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int          FRAME_OVERHEAD = 3;
  localparam logic [12:0] TIMEOUT_RESET  = 13'd4150;
  localparam logic [12:0] IDLE_MAX       = 13'h1fff;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic [4:0] body_index;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

/* sv/checked_frame_receiver.sv */
// ---------------------------------------------------------------------------
// checked_frame_receiver
// checks one header/length/body/checksum frame, passes out a status and its body bytes
// ---------------------------------------------------------------------------
//  channel | signals                                      | direction
//  in      | in_valid, in_stall, command, expected_header, | into block
//          | expected_length, data_byte                   |
//  out     | out_valid, out_stall, kind, body_byte,        | out of block
//          | body_index, status, last                     |
//  cfg     | psel, penable, pwrite, paddr, pwdata,         | apb register port
//          | prdata, pready                               |
//
//  one item per cycle while in_stall is low; its result is registered
//  the frame state updates in the cycle of the transfer, in a single pass
//  an output register plus one skid entry: in_stall rises only when both hold
//  a result
//  rst is synchronous; it clears the frame state and loads timeout_ticks 4150
// ---------------------------------------------------------------------------
`include "checked_frame_receiver_assert.svh"

module checked_frame_receiver
  import crf_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  expected_header,
  input  logic [4:0]  expected_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  body_byte,
  output logic [4:0]  body_index,
  output logic [1:0]  status,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW = $clog2(MAX_FRAME);
  localparam int CW = 7;

  logic [12:0]   timeout_ticks;
  logic          armed, armed_next;
  logic [7:0]    want_header, want_header_next;
  logic [4:0]    want_length, want_length_next;
  logic [BW-1:0] bytes_seen, bytes_seen_next;
  logic [7:0]    running_sum, running_sum_next;
  logic          header_bad, header_bad_next;
  logic [12:0]   idle_count, idle_count_next;

  logic          res_valid;
  result_t       res;
  logic          accept;
  logic          take;
  logic [CW-1:0] total;
  logic [CW-1:0] seen_ext;
  logic [CW-1:0] start_total;
  logic [CW-1:0] body_pos;
  logic [12:0]   idle_inc;

  logic          skid_valid;
  result_t       out_data, skid_data;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {19'd0, timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[12:0];
    end
  end

  // frame logic
  assign accept      = in_valid && !in_stall;
  assign take        = out_valid && !out_stall;
  assign total       = CW'(want_length) + CW'(FRAME_OVERHEAD);
  assign seen_ext    = CW'(bytes_seen);
  assign start_total = CW'(expected_length) + CW'(FRAME_OVERHEAD);
  assign body_pos    = seen_ext - CW'(2);
  assign idle_inc    = (idle_count < IDLE_MAX) ? idle_count + 13'd1 : idle_count;

  always_comb begin
    armed_next       = armed;
    want_header_next = want_header;
    want_length_next = want_length;
    bytes_seen_next  = bytes_seen;
    running_sum_next = running_sum;
    header_bad_next  = header_bad;
    idle_count_next  = idle_count;
    res_valid        = 1'b0;
    res              = '0;
    unique case (command)
      CMD_START: begin
        bytes_seen_next  = '0;
        running_sum_next = '0;
        header_bad_next  = 1'b0;
        idle_count_next  = '0;
        want_header_next = expected_header;
        want_length_next = expected_length;
        if (start_total > CW'(MAX_FRAME)) begin
          armed_next = 1'b0;
          res_valid  = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = ST_BADHDR;
          res.last   = 1'b1;
        end else begin
          armed_next = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (armed) begin
          idle_count_next = '0;
          priority if (seen_ext + CW'(1) >= total) begin
            armed_next      = 1'b0;
            bytes_seen_next = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.last        = 1'b1;
            if (header_bad) begin
              res.status = ST_BADHDR;
            end else if (running_sum != data_byte) begin
              res.status = ST_BADSUM;
            end else begin
              res.status = ST_OK;
            end
          end else begin
            running_sum_next = running_sum + data_byte;
            bytes_seen_next  = bytes_seen + BW'(1);
            if (bytes_seen == '0) begin
              if (data_byte != want_header) begin
                header_bad_next = 1'b1;
              end
            end else if (bytes_seen == BW'(1)) begin
              if (data_byte[4:0] != want_length || data_byte[7:5] != 3'd0) begin
                header_bad_next = 1'b1;
              end
            end else begin
              res_valid      = 1'b1;
              res.kind       = KIND_BODY;
              res.body_byte  = data_byte;
              res.body_index = body_pos[4:0];
            end
          end
        end
      end
      CMD_TICK: begin
        if (armed) begin
          idle_count_next = idle_inc;
          if (idle_inc >= timeout_ticks) begin
            armed_next      = 1'b0;
            bytes_seen_next = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.status      = ST_TIMEOUT;
            res.last        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      want_header <= '0;
      want_length <= '0;
      bytes_seen  <= '0;
      running_sum <= '0;
      header_bad  <= 1'b0;
      idle_count  <= '0;
    end else if (accept) begin
      armed       <= armed_next;
      want_header <= want_header_next;
      want_length <= want_length_next;
      bytes_seen  <= bytes_seen_next;
      running_sum <= running_sum_next;
      header_bad  <= header_bad_next;
      idle_count  <= idle_count_next;
    end
  end

  // output register and skid entry
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (accept && res_valid) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_data <= skid_data;
    end else if (accept && res_valid) begin
      if (!out_valid || take) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign kind       = out_data.kind;
  assign body_byte  = out_data.body_byte;
  assign body_index = out_data.body_index;
  assign status     = out_data.status;
  assign last       = out_data.last;

  // checks
  `CRF_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry full with empty output")
  `CRF_ASSERT(a_idle_cleared, !armed |-> bytes_seen == '0, "byte count left over while unarmed")
  `CRF_ASSERT(a_count_in_frame, armed |-> seen_ext < total, "byte count past frame end")
  `CRF_ASSERT(a_status_last, out_valid && kind == KIND_STATUS |-> last, "status result without last")
  `CRF_ASSERT(a_stall_full, $rose(in_stall) |-> $past(out_valid && out_stall), "stall without a held result")

endmodule

/* sim/tb_checked_frame_receiver.sv */
// ---------------------------------------------------------------------------
// tb_checked_frame_receiver
// self-checking testbench for the checked frame receiver
// ---------------------------------------------------------------------------
// a queue of pending items feeds a clocked driver that sends them in bursts
// with random gaps; a clocked monitor compares every result transfer with
// the oldest prediction of an in-testbench frame model. a short directed
// list comes first, then random frames (good, bad header, bad length, bad
// checksum, timeout, restarted) mixed with noise, over several timeout
// settings written through the register port between phases
// ---------------------------------------------------------------------------
module tb_checked_frame_receiver;
  import crf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int ERR_SHOWN = 10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] header;
    logic [4:0] length;
    logic [7:0] data;
  } rx_item_t;

  typedef enum int {
    FR_GOOD, FR_BAD_HDR, FR_BAD_LEN, FR_BAD_SUM, FR_TIMEOUT, FR_RESTART
  } frame_variant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_START;
  logic [7:0]  expected_header = 8'd0;
  logic [4:0]  expected_length = 5'd0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  body_byte;
  logic [4:0]  body_index;
  logic [1:0]  status;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  checked_frame_receiver i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .expected_header(expected_header), .expected_length(expected_length),
    .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .body_byte(body_byte), .body_index(body_index), .status(status), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  rx_item_t pending_items[$];
  result_t  due_results[$];

  // frame model state
  logic        fm_armed = 1'b0;
  logic [7:0]  fm_header = 8'd0;
  logic [4:0]  fm_length = 5'd0;
  logic [4:0]  fm_seen = 5'd0;
  logic [7:0]  fm_sum = 8'd0;
  logic        fm_hdr_bad = 1'b0;
  logic [12:0] fm_idle = 13'd0;
  logic [12:0] fm_timeout = TIMEOUT_RESET;

  int n_errors = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_body = 0;
  int n_status[4] = '{0, 0, 0, 0};

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= ERR_SHOWN) $display("ERROR: %s", msg);
  endtask

  task automatic predict_frame_step(input rx_item_t it);
    result_t r;
    bit      has;
    r = '0;
    has = 1'b0;
    case (it.command)
      CMD_START: begin
        fm_seen = 5'd0;
        fm_sum = 8'd0;
        fm_hdr_bad = 1'b0;
        fm_idle = 13'd0;
        fm_header = it.header;
        fm_length = it.length;
        if (int'(it.length) + FRAME_OVERHEAD > MAX_FRAME_DEF) begin
          fm_armed = 1'b0;
          r.kind = KIND_STATUS;
          r.status = ST_BADHDR;
          r.last = 1'b1;
          has = 1'b1;
        end else begin
          fm_armed = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (fm_armed) begin
          fm_idle = 13'd0;
          if (int'(fm_seen) + 1 >= int'(fm_length) + FRAME_OVERHEAD) begin
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            if (fm_hdr_bad) r.status = ST_BADHDR;
            else if (fm_sum != it.data) r.status = ST_BADSUM;
            else r.status = ST_OK;
            fm_armed = 1'b0;
            fm_seen = 5'd0;
            has = 1'b1;
          end else begin
            fm_sum = fm_sum + it.data;
            if (fm_seen == 5'd0) begin
              if (it.data != fm_header) fm_hdr_bad = 1'b1;
            end else if (fm_seen == 5'd1) begin
              if (it.data != 8'(fm_length)) fm_hdr_bad = 1'b1;
            end else begin
              r.kind = KIND_BODY;
              r.body_byte = it.data;
              r.body_index = fm_seen - 5'd2;
              has = 1'b1;
            end
            fm_seen = fm_seen + 5'd1;
          end
        end
      end
      CMD_TICK: begin
        if (fm_armed) begin
          if (fm_idle < IDLE_MAX) fm_idle = fm_idle + 13'd1;
          if (fm_idle >= fm_timeout) begin
            fm_armed = 1'b0;
            fm_seen = 5'd0;
            r.kind = KIND_STATUS;
            r.status = ST_TIMEOUT;
            r.last = 1'b1;
            has = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (has) begin
      due_results.push_back(r);
      if (r.kind == KIND_BODY) n_body++;
      else n_status[r.status]++;
    end
  endtask

  // sender: bursts with random gaps
  int       burst_left = 0;
  int       gap_left = 0;
  rx_item_t drive_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame_step(drive_item);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          command <= drive_item.command;
          expected_header <= drive_item.header;
          expected_length <= drive_item.length;
          data_byte <= drive_item.data;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(8, 20);
              default: gap_left = $urandom_range(1, 3);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;

  always @(posedge clk) begin
    cyc++;
    if ($urandom_range(0, 79) == 0) stall_mode = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= cyc[1];
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // result check
  result_t got_result;
  result_t want_result;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result.kind = kind;
      got_result.body_byte = body_byte;
      got_result.body_index = body_index;
      got_result.status = status;
      got_result.last = last;
      if (due_results.size() == 0) begin
        note_error($sformatf("result with nothing expected: kind %0d byte %02h idx %0d st %0d last %0d",
                             kind, body_byte, body_index, status, last));
      end else begin
        want_result = due_results.pop_front();
        if (got_result.kind !== want_result.kind ||
            got_result.body_byte !== want_result.body_byte ||
            got_result.body_index !== want_result.body_index ||
            got_result.status !== want_result.status ||
            got_result.last !== want_result.last)
          note_error($sformatf({"exp kind %0d byte %02h idx %0d st %0d last %0d, ",
                                "got kind %0d byte %02h idx %0d st %0d last %0d"},
                               want_result.kind, want_result.body_byte,
                               want_result.body_index, want_result.status,
                               want_result.last, got_result.kind, got_result.body_byte,
                               got_result.body_index, got_result.status,
                               got_result.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("checked_frame_receiver: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] hdr,
                            input logic [4:0] len, input logic [7:0] b);
    rx_item_t it;
    it.command = cmd;
    it.header = hdr;
    it.length = len;
    it.data = b;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic queue_filler(input logic [1:0] cmd, input logic [7:0] b);
    queue_item(cmd, 8'($urandom), 5'($urandom), b);
  endtask

  task automatic queue_ticks();
    int n;
    if (fm_timeout >= 13'd2 && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, (fm_timeout > 13'd6) ? 5 : int'(fm_timeout) - 1);
      repeat (n) queue_filler(CMD_TICK, 8'($urandom));
    end
  endtask

  task automatic queue_noise();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) queue_filler(2'($urandom_range(1, 3)), 8'($urandom));
  endtask

  function automatic frame_variant_t pick_variant();
    int r;
    frame_variant_t v;
    r = $urandom_range(0, 99);
    if (r < 58) v = FR_GOOD;
    else if (r < 66) v = FR_BAD_HDR;
    else if (r < 73) v = FR_BAD_LEN;
    else if (r < 83) v = FR_BAD_SUM;
    else if (r < 93) v = FR_TIMEOUT;
    else v = FR_RESTART;
    if (v == FR_TIMEOUT && fm_timeout > 13'd64) v = FR_GOOD;
    return v;
  endfunction

  task automatic queue_frame(input frame_variant_t v);
    logic [7:0] hdr;
    logic [7:0] b;
    logic [7:0] sum;
    logic [4:0] len;
    int         r;
    int         total;
    int         cut;
    hdr = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 14) len = 5'($urandom_range(0, 6));
    else if (r < 18) len = 5'($urandom_range(7, 21));
    else len = 5'($urandom_range(22, 31));
    queue_item(CMD_START, hdr, len, 8'($urandom));
    if (len > 5'd21) return;
    total = int'(len) + FRAME_OVERHEAD;
    cut = $urandom_range(0, total - 2);
    sum = 8'd0;
    for (int i = 0; i < total - 1; i++) begin
      if (i == 0) b = hdr;
      else if (i == 1) b = 8'(len);
      else b = 8'($urandom);
      if (v == FR_BAD_HDR && i == 0) b = b ^ 8'($urandom_range(1, 255));
      if (v == FR_BAD_LEN && i == 1) b = b ^ 8'($urandom_range(1, 255));
      queue_ticks();
      if (v == FR_TIMEOUT && i == cut) begin
        repeat ((fm_timeout == 13'd0) ? 1 : int'(fm_timeout)) queue_filler(CMD_TICK, 8'($urandom));
        return;
      end
      if (v == FR_RESTART && i == cut) return;
      queue_item(CMD_BYTE, 8'($urandom), 5'($urandom), b);
      sum = sum + b;
    end
    queue_ticks();
    if (v == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    queue_item(CMD_BYTE, 8'($urandom), 5'($urandom), sum);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [12:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_TIMEOUT);
    pwdata <= {19'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fm_timeout = value;
  endtask

  task automatic run_phase(input logic [12:0] tmo, input int budget);
    int base;
    wait_idle();
    write_timeout(tmo);
    base = n_queued;
    while (n_queued - base < budget) begin
      queue_frame(pick_variant());
      queue_noise();
    end
    queue_frame(FR_GOOD);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ignored while not armed
    queue_filler(CMD_BYTE, 8'h3c);
    queue_filler(CMD_TICK, 8'hc3);
    queue_filler(CMD_UNUSED, 8'h5a);
    // shortest good frame
    queue_item(CMD_START, 8'hff, 5'd0, 8'h00);
    queue_filler(CMD_BYTE, 8'hff);
    queue_filler(CMD_BYTE, 8'h00);
    queue_filler(CMD_BYTE, 8'hff);
    // frames too long for the buffer
    queue_item(CMD_START, 8'h00, 5'd31, 8'hff);
    queue_item(CMD_START, 8'h5a, 5'd22, 8'h00);
    // wrong header with a body byte, status must not be bad checksum
    queue_item(CMD_START, 8'ha5, 5'd1, 8'h00);
    queue_filler(CMD_BYTE, 8'ha4);
    queue_filler(CMD_BYTE, 8'h01);
    queue_filler(CMD_BYTE, 8'hff);
    queue_filler(CMD_BYTE, 8'h23);
    // wrong checksum
    queue_item(CMD_START, 8'h12, 5'd0, 8'h00);
    queue_filler(CMD_BYTE, 8'h12);
    queue_filler(CMD_BYTE, 8'h00);
    queue_filler(CMD_BYTE, 8'h00);
    // start while armed drops the frame in progress
    queue_item(CMD_START, 8'h33, 5'd2, 8'h00);
    queue_item(CMD_START, 8'h00, 5'd0, 8'h00);
    queue_filler(CMD_BYTE, 8'h00);
    queue_filler(CMD_BYTE, 8'h00);
    queue_filler(CMD_BYTE, 8'h00);

    run_phase(13'd1, 55);
    run_phase(13'd0, 40);
    run_phase(13'h1fff, 45);
    run_phase(13'($urandom_range(2, 12)), 120);
    run_phase(13'($urandom_range(13, 60)), 95);

    wait_idle();
    repeat (4) @(posedge clk);
    if (due_results.size() != 0)
      note_error($sformatf("%0d results never arrived", due_results.size()));
    $display("run covered %0d transfers in, %0d body bytes out", n_accepted, n_body);
    $display("frame status seen: ok %0d, timeout %0d, bad header %0d, bad checksum %0d",
             n_status[ST_OK], n_status[ST_TIMEOUT], n_status[ST_BADHDR], n_status[ST_BADSUM]);
    if (n_errors == 0) begin
      $display("checked_frame_receiver: match");
    end else begin
      $display("checked_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
